// File: hw/rtl/ndg_pkg.sv
package ndg_pkg;

   localparam int unsigned MAX_DIMENSION = 2048;

   localparam int unsigned DIM_W   = 12;
   localparam int unsigned COORD_W = 11;
   localparam int unsigned ACC_W   = 23;
   localparam int unsigned PIXEL_W = 24;
   localparam int unsigned GRAY_W  = 8;
   localparam int unsigned LUMA_W  = 16;

   localparam int unsigned PADDR_W   = 5;
   localparam int unsigned PDATA_W   = 32;
   localparam int unsigned REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE    = 3'd4;

   localparam logic FMT_RGB565 = 1'b0;
   localparam logic FMT_RGB888 = 1'b1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd160;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd120;
   localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(MAX_DIMENSION);
   localparam logic [DIM_W-1:0] DIM_ONE      = 12'd1;

   // 0.299, 0.587, 0.114 scaled by 256
   localparam logic [7:0] COEF_R = 8'd77;
   localparam logic [7:0] COEF_G = 8'd150;
   localparam logic [7:0] COEF_B = 8'd29;

   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] dst_w;
      logic [DIM_W-1:0] dst_h;
      logic             color_mode;
   } cfg_type;

   typedef struct packed {
      logic               keep;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               frame_end;
   } sel_type;

endpackage

// File: hw/rtl/ndg_req_if.sv
interface ndg_req_if;
   logic                         valid;
   logic                         ready;
   logic [ndg_pkg::PIXEL_W-1:0]  pixel_word;
   logic                         frame_start;

   modport source (output valid, output pixel_word, output frame_start, input ready);
   modport sink (input valid, input pixel_word, input frame_start, output ready);
endinterface

// File: hw/rtl/ndg_rsp_if.sv
interface ndg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ndg_pkg::GRAY_W-1:0]   gray;
   logic [ndg_pkg::COORD_W-1:0]  out_x;
   logic [ndg_pkg::COORD_W-1:0]  out_y;
   logic                         frame_end;

   modport source (output valid, output gray, output out_x, output out_y, output frame_end,
                   input ready);
   modport sink (input valid, input gray, input out_x, input out_y, input frame_end,
                 output ready);
endinterface

// File: hw/rtl/nearest_downscale_to_gray.sv
// path: a req transfer loads the input stage, and a kept pixel then moves to the result register
// throughput: one pixel per cycle, the selection counters stepping once per pixel;
// dropped pixels keep moving while rsp stalls, a kept one waits for the result slot
// reset (synchronous, active high) loads 160x120 to 160x120, RGB565, and
// restarts the frame counters; any write to a defined register restarts them as well
module nearest_downscale_to_gray (
   input  logic                          clock,
   input  logic                          reset,
   ndg_req_if.sink                       req,
   ndg_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ndg_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [ndg_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [ndg_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   ndg_pkg::cfg_type              cfg;
   ndg_pkg::sel_type              sel;
   logic                          restart;

   logic                          in_valid_ff, in_valid_in;
   logic [ndg_pkg::PIXEL_W-1:0]   in_word_ff;
   logic                          in_start_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ndg_pkg::GRAY_W-1:0]    gray_ff, gray_in;
   logic [ndg_pkg::COORD_W-1:0]   out_x_ff, out_y_ff;
   logic                          frame_end_ff;
   logic                          accept, advance;

   ndg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .restart (restart)
   );

   ndg_select u_select (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .restart     (restart),
      .step        (advance),
      .frame_start (in_start_ff),
      .sel         (sel)
   );

   ndg_luma u_luma (
      .color_mode (cfg.color_mode),
      .pixel_word (in_word_ff),
      .gray       (gray_in)
   );

   // a dropped pixel always moves on; a kept one needs the result slot
   assign advance   = in_valid_ff && (!sel.keep || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && sel.keep) || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff  <= req.pixel_word;
         in_start_ff <= req.frame_start;
      end
      if (advance && sel.keep) begin
         gray_ff      <= gray_in;
         out_x_ff     <= sel.out_x;
         out_y_ff     <= sel.out_y;
         frame_end_ff <= sel.frame_end;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.gray      = gray_ff;
   assign rsp.out_x     = out_x_ff;
   assign rsp.out_y     = out_y_ff;
   assign rsp.frame_end = frame_end_ff;

`ifndef SYNTH
   a_coords_in_target : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, out_x_ff} < cfg.dst_w) && ({1'b0, out_y_ff} < cfg.dst_h))
      else $error("result coordinates outside the target frame");

   a_frame_end_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_end_ff |->
         ({1'b0, out_x_ff} + 12'd1 == cfg.dst_w) && ({1'b0, out_y_ff} + 12'd1 == cfg.dst_h))
      else $error("frame end marked away from the last target pixel");

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted pixel missing from the input stage");

   a_kept_lands : assert property (@(posedge clock) disable iff (reset)
      advance && sel.keep |=> rsp_valid_ff)
      else $error("kept pixel missing from the result register");
`endif

endmodule

// File: hw/rtl/ndg_csr.sv
module ndg_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ndg_pkg::PADDR_W-1:0]   paddr,
   input  logic [ndg_pkg::PDATA_W-1:0]   pwdata,
   output logic [ndg_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output ndg_pkg::cfg_type              cfg,
   output logic                          restart
);

   logic [ndg_pkg::DIM_W-1:0]     source_width_ff, source_height_ff;
   logic [ndg_pkg::DIM_W-1:0]     target_width_ff, target_height_ff;
   logic                          color_mode_ff;
   logic [ndg_pkg::REG_IDX_W-1:0] index;
   logic                          write_en;
   logic                          index_ok;

   assign index    = paddr[ndg_pkg::PADDR_W-1:2];
   assign write_en = psel && penable && pwrite;
   assign index_ok = (index == ndg_pkg::REG_SOURCE_WIDTH) ||
                     (index == ndg_pkg::REG_SOURCE_HEIGHT) ||
                     (index == ndg_pkg::REG_TARGET_WIDTH) ||
                     (index == ndg_pkg::REG_TARGET_HEIGHT) ||
                     (index == ndg_pkg::REG_COLOR_MODE);
   assign restart  = write_en && index_ok;
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= ndg_pkg::RESET_WIDTH;
         source_height_ff <= ndg_pkg::RESET_HEIGHT;
         target_width_ff  <= ndg_pkg::RESET_WIDTH;
         target_height_ff <= ndg_pkg::RESET_HEIGHT;
         color_mode_ff    <= ndg_pkg::FMT_RGB565;
      end else if (write_en) begin
         unique case (index)
            ndg_pkg::REG_SOURCE_WIDTH:  source_width_ff  <= pwdata[ndg_pkg::DIM_W-1:0];
            ndg_pkg::REG_SOURCE_HEIGHT: source_height_ff <= pwdata[ndg_pkg::DIM_W-1:0];
            ndg_pkg::REG_TARGET_WIDTH:  target_width_ff  <= pwdata[ndg_pkg::DIM_W-1:0];
            ndg_pkg::REG_TARGET_HEIGHT: target_height_ff <= pwdata[ndg_pkg::DIM_W-1:0];
            ndg_pkg::REG_COLOR_MODE:    color_mode_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ndg_pkg::REG_SOURCE_WIDTH:  prdata = ndg_pkg::PDATA_W'(source_width_ff);
         ndg_pkg::REG_SOURCE_HEIGHT: prdata = ndg_pkg::PDATA_W'(source_height_ff);
         ndg_pkg::REG_TARGET_WIDTH:  prdata = ndg_pkg::PDATA_W'(target_width_ff);
         ndg_pkg::REG_TARGET_HEIGHT: prdata = ndg_pkg::PDATA_W'(target_height_ff);
         ndg_pkg::REG_COLOR_MODE:    prdata = ndg_pkg::PDATA_W'(color_mode_ff);
         default:                    prdata = '0;
      endcase
   end

   // zero reads as one, source saturates, target clamps to source
   always_comb begin
      if (source_width_ff == '0)                   cfg.src_w = ndg_pkg::DIM_ONE;
      else if (source_width_ff > ndg_pkg::DIM_MAX) cfg.src_w = ndg_pkg::DIM_MAX;
      else                                         cfg.src_w = source_width_ff;

      if (source_height_ff == '0)                   cfg.src_h = ndg_pkg::DIM_ONE;
      else if (source_height_ff > ndg_pkg::DIM_MAX) cfg.src_h = ndg_pkg::DIM_MAX;
      else                                          cfg.src_h = source_height_ff;

      if (target_width_ff == '0)             cfg.dst_w = ndg_pkg::DIM_ONE;
      else if (target_width_ff > cfg.src_w)  cfg.dst_w = cfg.src_w;
      else                                   cfg.dst_w = target_width_ff;

      if (target_height_ff == '0)            cfg.dst_h = ndg_pkg::DIM_ONE;
      else if (target_height_ff > cfg.src_h) cfg.dst_h = cfg.src_h;
      else                                   cfg.dst_h = target_height_ff;

      cfg.color_mode = color_mode_ff;
   end

endmodule

// File: hw/rtl/ndg_luma.sv
module ndg_luma (
   input  logic                         color_mode,
   input  logic [ndg_pkg::PIXEL_W-1:0]  pixel_word,
   output logic [ndg_pkg::GRAY_W-1:0]   gray
);

   logic [7:0]                  red, green, blue;
   logic [ndg_pkg::LUMA_W-1:0]  sum;

   always_comb begin
      if (color_mode == ndg_pkg::FMT_RGB888) begin
         red   = pixel_word[23:16];
         green = pixel_word[15:8];
         blue  = pixel_word[7:0];
      end else begin
         // widen by shifting, no bit replication
         red   = {pixel_word[15:11], 3'b000};
         green = {pixel_word[10:5], 2'b00};
         blue  = {pixel_word[4:0], 3'b000};
      end
   end

   assign sum = ndg_pkg::LUMA_W'(ndg_pkg::COEF_R) * ndg_pkg::LUMA_W'(red) +
                ndg_pkg::LUMA_W'(ndg_pkg::COEF_G) * ndg_pkg::LUMA_W'(green) +
                ndg_pkg::LUMA_W'(ndg_pkg::COEF_B) * ndg_pkg::LUMA_W'(blue);
   assign gray = sum[ndg_pkg::LUMA_W-1:ndg_pkg::LUMA_W-ndg_pkg::GRAY_W];

endmodule

// File: hw/rtl/ndg_select.sv
module ndg_select (
   input  logic                 clock,
   input  logic                 reset,
   input  ndg_pkg::cfg_type     cfg,
   input  logic                 restart,
   input  logic                 step,
   input  logic                 frame_start,
   output ndg_pkg::sel_type     sel
);

   localparam int unsigned DW = ndg_pkg::DIM_W;
   localparam int unsigned AW = ndg_pkg::ACC_W;

   logic [ndg_pkg::COORD_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DW-1:0]               dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [AW-1:0]               col_t_ff, col_t_in, col_s_ff, col_s_in;
   logic [AW-1:0]               row_t_ff, row_t_in, row_s_ff, row_s_in;
   logic                        row_sel_ff, row_sel_in;
   logic                        pending_ff;

   logic                        restart_now;
   logic [ndg_pkg::COORD_W-1:0] cur_src_col, cur_src_row;
   logic [DW-1:0]               cur_dst_col, cur_dst_row;
   logic [AW-1:0]               cur_col_t, cur_col_s, cur_row_t, cur_row_s;
   logic                        cur_row_sel;
   logic [DW-1:0]               src_col_inc, src_row_inc;
   logic [AW-1:0]               row_t_next, row_s_next;

   // a register write or frame_start puts the counters back to frame start
   assign restart_now = frame_start || pending_ff;

   always_comb begin
      if (restart_now) begin
         cur_src_col = '0;
         cur_src_row = '0;
         cur_dst_col = '0;
         cur_dst_row = '0;
         cur_col_t   = '0;
         cur_col_s   = AW'(cfg.dst_w);
         cur_row_t   = '0;
         cur_row_s   = AW'(cfg.dst_h);
         cur_row_sel = 1'b1;
      end else begin
         cur_src_col = src_col_ff;
         cur_src_row = src_row_ff;
         cur_dst_col = dst_col_ff;
         cur_dst_row = dst_row_ff;
         cur_col_t   = col_t_ff;
         cur_col_s   = col_s_ff;
         cur_row_t   = row_t_ff;
         cur_row_s   = row_s_ff;
         cur_row_sel = row_sel_ff;
      end
   end

   always_comb begin
      sel.keep      = cur_row_sel && (cur_col_t < cur_col_s);
      sel.out_x     = cur_dst_col[ndg_pkg::COORD_W-1:0];
      sel.out_y     = cur_dst_row[ndg_pkg::COORD_W-1:0];
      sel.frame_end = ({1'b0, cur_dst_col} + 13'd1 == {1'b0, cfg.dst_w}) &&
                      ({1'b0, cur_dst_row} + 13'd1 == {1'b0, cfg.dst_h});
   end

   always_comb begin
      src_col_inc = DW'(cur_src_col) + DW'(1);
      src_row_inc = DW'(cur_src_row) + DW'(1);
      row_t_next  = cur_row_sel ? cur_row_t + AW'(cfg.src_h) : cur_row_t;
      row_s_next  = cur_row_s + AW'(cfg.dst_h);

      src_row_in = cur_src_row;
      dst_row_in = cur_dst_row;
      row_t_in   = cur_row_t;
      row_s_in   = cur_row_s;
      row_sel_in = cur_row_sel;

      if (src_col_inc >= cfg.src_w) begin
         // end of source line
         src_col_in = '0;
         dst_col_in = '0;
         col_t_in   = '0;
         col_s_in   = AW'(cfg.dst_w);
         if (src_row_inc >= cfg.src_h) begin
            src_row_in = '0;
            dst_row_in = '0;
            row_t_in   = '0;
            row_s_in   = AW'(cfg.dst_h);
            row_sel_in = 1'b1;
         end else begin
            src_row_in = src_row_inc[ndg_pkg::COORD_W-1:0];
            dst_row_in = cur_row_sel ? cur_dst_row + DW'(1) : cur_dst_row;
            row_t_in   = row_t_next;
            row_s_in   = row_s_next;
            row_sel_in = row_t_next < row_s_next;
         end
      end else begin
         src_col_in = src_col_inc[ndg_pkg::COORD_W-1:0];
         dst_col_in = sel.keep ? cur_dst_col + DW'(1) : cur_dst_col;
         col_t_in   = sel.keep ? cur_col_t + AW'(cfg.src_w) : cur_col_t;
         col_s_in   = cur_col_s + AW'(cfg.dst_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         col_t_ff   <= '0;
         col_s_ff   <= '0;
         row_t_ff   <= '0;
         row_s_ff   <= '0;
         row_sel_ff <= 1'b1;
         pending_ff <= 1'b1;
      end else if (restart) begin
         pending_ff <= 1'b1;
      end else if (step) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
         col_t_ff   <= col_t_in;
         col_s_ff   <= col_s_in;
         row_t_ff   <= row_t_in;
         row_s_ff   <= row_s_in;
         row_sel_ff <= row_sel_in;
         pending_ff <= 1'b0;
      end
   end

endmodule
